[rtl/utf8d_pkg.sv]
// shared types and constants for the utf-8 stream decoder
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CP_W            = 21;
  localparam int LEN_W           = 3;
  localparam int CNT_OUT_W       = 16;
  localparam int PART_W          = 15;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CP_W-1:0]  CP_SPACE    = 21'h000020;
  localparam logic [CP_W-1:0]  CP_QUESTION = 21'h00003F;
  localparam logic [CP_W-1:0]  CP_BMP_MAX  = 21'h00FFFF;

  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

  // lead byte classes
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // one assembled codepoint passed from front to back
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
  } q_entry_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic lead_kind_t classify(input logic [7:0] b);
    lead_kind_t k;
    priority if (b[7] == 1'b0)        k = LEAD_ASCII;
    else if (b[7:5] == 3'b110)        k = LEAD_TWO;
    else if (b[7:4] == 4'b1110)       k = LEAD_THREE;
    else if (b[7:3] == 5'b11110)      k = LEAD_FOUR;
    else                              k = LEAD_BAD;
    return k;
  endfunction

endpackage

[rtl/utf8d_if.sv]
// valid/ready channel interfaces for bytes, codepoints and the mode register
`timescale 1ns / 1ps

interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic [2:0]  seq_length;
  logic        end_of_string;
  logic [15:0] char_count;
  modport source (output valid, output codepoint, output seq_length,
                  output end_of_string, output char_count, input ready);
  modport sink   (input valid, input codepoint, input seq_length,
                  input end_of_string, input char_count, output ready);
endinterface

interface utf8d_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/utf8d_front.sv]
// front end: takes bytes, classifies lead bytes and assembles sequences
`timescale 1ns / 1ps

module utf8d_front (
  input  logic                clk,
  input  logic                rst_n,
  utf8d_in_if.sink            in_ch,
  input  utf8d_pkg::q_status_t q_stat,
  output logic                push,
  output utf8d_pkg::q_entry_t push_data
);
  import utf8d_pkg::*;

  logic [PART_W-1:0] part_r, part_nxt;
  logic [1:0]        rem_r, rem_nxt;
  logic [LEN_W-1:0]  tot_r, tot_nxt;
  logic              accept;
  logic [CP_W-1:0]   joined;
  lead_kind_t        kind;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign joined      = {part_r, in_ch.in_byte[5:0]};
  assign kind        = classify(in_ch.in_byte);

  // sequence assembly and push decision
  always_comb begin
    part_nxt      = part_r;
    rem_nxt       = rem_r;
    tot_nxt       = tot_r;
    push          = 1'b0;
    push_data.cp  = joined;
    push_data.len = tot_r;
    if (accept) begin
      if (rem_r != 2'd0) begin
        rem_nxt = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          push     = 1'b1;
          part_nxt = '0;
          tot_nxt  = '0;
        end else begin
          part_nxt = joined[PART_W-1:0];
        end
      end else begin
        unique case (kind)
          LEAD_ASCII: begin
            push          = 1'b1;
            push_data.cp  = {13'd0, in_ch.in_byte};
            push_data.len = LEN_1;
          end
          LEAD_TWO: begin
            part_nxt = {10'd0, in_ch.in_byte[4:0]};
            rem_nxt  = 2'd1;
            tot_nxt  = LEN_2;
          end
          LEAD_THREE: begin
            part_nxt = {11'd0, in_ch.in_byte[3:0]};
            rem_nxt  = 2'd2;
            tot_nxt  = LEN_3;
          end
          LEAD_FOUR: begin
            part_nxt = {12'd0, in_ch.in_byte[2:0]};
            rem_nxt  = 2'd3;
            tot_nxt  = LEN_4;
          end
          default: begin
            push          = 1'b1;
            push_data.cp  = CP_SPACE;
            push_data.len = LEN_1;
          end
        endcase
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      rem_r  <= '0;
      tot_r  <= '0;
    end else begin
      part_r <= part_nxt;
      rem_r  <= rem_nxt;
      tot_r  <= tot_nxt;
    end
  end

endmodule

[rtl/utf8d_fifo.sv]
// short queue between the front end and the back end
`timescale 1ns / 1ps

module utf8d_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utf8d_pkg::q_entry_t  push_data,
  input  logic                 pop,
  output utf8d_pkg::q_entry_t  pop_data,
  output utf8d_pkg::q_status_t stat
);
  import utf8d_pkg::*;

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr_r];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/utf8d_back.sv]
// back end: mode replacement, terminator detect, string counter, output register
`timescale 1ns / 1ps

module utf8d_back #(
  parameter int COUNT_WIDTH = utf8d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  utf8d_cfg_if.sink           cfg_ch,
  input  logic                q_empty,
  input  utf8d_pkg::q_entry_t q_data,
  output logic                pop,
  utf8d_out_if.source         out_ch
);
  import utf8d_pkg::*;

  logic                   bmp_only_r;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   out_valid_r;
  logic [CP_W-1:0]        cp_r, cp_nxt;
  logic [LEN_W-1:0]       len_r;
  logic                   eos_r, eos_nxt;
  logic [CNT_OUT_W-1:0]   char_r;
  logic [31:0]            cnt_wide;
  logic                   load;

  assign cfg_ch.ready = 1'b1;
  assign load         = !out_valid_r || out_ch.ready;
  assign pop          = load && !q_empty;

  // replacement, terminator and count update
  always_comb begin
    cp_nxt = (bmp_only_r && (q_data.cp > CP_BMP_MAX)) ? CP_QUESTION : q_data.cp;
    eos_nxt = (cp_nxt == '0);
    if (eos_nxt) begin
      cnt_nxt = '0;
    end else if (cnt_r != '1) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
    cnt_wide = '0;
    cnt_wide[COUNT_WIDTH-1:0] = cnt_r;
  end

  // mode register, counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bmp_only_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        bmp_only_r <= cfg_ch.data;
      end
      if (pop) begin
        cnt_r <= cnt_nxt;
      end
      if (load) begin
        out_valid_r <= !q_empty;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cp_r   <= cp_nxt;
      len_r  <= q_data.len;
      eos_r  <= eos_nxt;
      char_r <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.codepoint     = cp_r;
  assign out_ch.seq_length    = len_r;
  assign out_ch.end_of_string = eos_r;
  assign out_ch.char_count    = char_r;

endmodule

[rtl/utf8_stream_decoder_top.sv]
// top level of the utf-8 stream decoder
// each codepoint passes through the queue and then the output register as its result beat
// throughput: one byte per cycle while the queue is not full; the two-entry queue lets
//   the front keep taking bytes while the output register waits on a stalled sink
// reset (rst_n, synchronous): clears the sequence state, queue, string counter,
//   output valid and the bmp_only mode bit
`timescale 1ns / 1ps

module utf8_stream_decoder_top #(
  parameter int COUNT_WIDTH = utf8d_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_in_if.sink    in_ch,
  utf8d_out_if.source out_ch,
  utf8d_cfg_if.sink   cfg_ch
);
  import utf8d_pkg::*;

  q_status_t q_stat;
  q_entry_t  push_data, pop_data;
  logic      push, pop;

  // byte intake and sequence assembly
  utf8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  utf8d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // result formation and output beat
  utf8d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .q_empty (q_stat.empty),
    .q_data  (pop_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
